// ===== src/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 stream transcoder.
// No dependencies; all other files but u2u_checker refer to this package by scoped names.
package u2u_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CP_W-1:0]   CP_PLANE1 = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

    // Continuation bytes still owed after a lead byte.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_3    = 2'd3;

    // Number of results pushed by one decoded item.
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              run_last;
        logic              string_end;
        logic              truncated;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== src/u2u_if.sv =====
// Valid/ready channel interfaces for the transcoder: byte input and unit output.
// Depends on u2u_pkg for field widths.
interface u2u_in_if;
    logic                          valid;
    logic                          ready;
    logic [u2u_pkg::BYTE_W-1:0]    byte_in;
    logic                          final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface u2u_out_if;
    logic                          valid;
    logic                          ready;
    logic [u2u_pkg::UNIT_W-1:0]    unit;
    logic                          run_last;
    logic                          string_end;
    logic                          truncated;

    modport source (output valid, output unit, output run_last, output string_end,
                    output truncated, input ready);
    modport sink   (input valid, input unit, input run_last, input string_end,
                    input truncated, output ready);
endinterface

// ===== src/utf8_to_utf16_stream.sv =====
// Top level of the UTF-8 to UTF-16 stream transcoder.
// Depends on u2u_pkg, u2u_if, u2u_decode and u2u_outq.
//
//   channel   dir   handshake        payload
//   i_in      in    valid / ready    byte_in[7:0], final_byte
//   o_out     out   valid / ready    unit[15:0], run_last, string_end, truncated
//
// One byte is taken per cycle unless stalled; it is held and decoded in the input
// register, and its units land in a four-entry queue that drains one unit per
// cycle while o_out is ready. Units go from the input register to the queue, then out.
// The input register advances only while the queue has room for two units.
// Synchronous active-low reset empties the pipe and the sequence state.
module utf8_to_utf16_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2u_in_if.sink      i_in,
    u2u_out_if.source   o_out
);

    u2u_pkg::t_push push;
    logic           room;

    u2u_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    u2u_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ===== src/u2u_decode.sv =====
// Input register, sequence state and decode of one byte into up to two units.
// Depends on u2u_pkg and u2u_in_if.
module u2u_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u2u_in_if.sink          i_in,
    input  logic            i_room,
    output u2u_pkg::t_push  o_push
);

    logic                          r_in_valid;
    logic [u2u_pkg::BYTE_W-1:0]    r_byte;
    logic                          r_fin;
    logic [1:0]                    r_pending;
    logic [u2u_pkg::CP_W-1:0]      r_accum;

    logic [1:0]                    n_pending;
    logic [u2u_pkg::CP_W-1:0]      n_accum;
    logic                          advance;
    logic                          done;
    logic [u2u_pkg::CP_W-1:0]      cp;
    logic [u2u_pkg::CP_W-1:0]      off;
    logic [1:0]                    step_pending;
    logic [u2u_pkg::CP_W-1:0]      step_accum;

    assign advance    = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.byte_in;
            r_fin  <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= u2u_pkg::PEND_NONE;
            r_accum   <= '0;
        end else if (advance) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

    always_comb begin
        done         = 1'b0;
        step_pending = r_pending;
        step_accum   = r_accum;
        cp           = '0;
        if (r_pending == u2u_pkg::PEND_NONE) begin
            if (!r_byte[7]) begin
                done = 1'b1;
                cp   = {13'd0, r_byte};
            end else if (r_byte[7:5] == 3'b110) begin
                step_accum   = {16'd0, r_byte[4:0]};
                step_pending = u2u_pkg::PEND_ONE;
            end else if (r_byte[7:4] == 4'b1110) begin
                step_accum   = {17'd0, r_byte[3:0]};
                step_pending = u2u_pkg::PEND_TWO;
            end else begin
                // any other lead, stray continuations too: four-byte form
                step_accum   = {18'd0, r_byte[2:0]};
                step_pending = u2u_pkg::PEND_3;
            end
        end else begin
            step_accum   = {r_accum[14:0], r_byte[5:0]};
            step_pending = r_pending - 2'd1;
            if (step_pending == u2u_pkg::PEND_NONE) begin
                done = 1'b1;
                cp   = step_accum;
            end
        end

        // the string end and a finished code point both return to idle
        if (r_fin || done) begin
            n_pending = u2u_pkg::PEND_NONE;
            n_accum   = '0;
        end else begin
            n_pending = step_pending;
            n_accum   = step_accum;
        end

        off = cp - u2u_pkg::CP_PLANE1;

        o_push.first  = '0;
        o_push.second = '0;
        o_push.count  = u2u_pkg::PUSH_NONE;
        if (done) begin
            if (cp[20:16] == 5'd0) begin
                o_push.first.unit       = cp[15:0];
                o_push.first.run_last   = 1'b1;
                o_push.first.string_end = r_fin;
                o_push.count            = u2u_pkg::PUSH_ONE;
            end else begin
                o_push.first.unit        = u2u_pkg::HI_SURR + {5'd0, off[20:10]};
                o_push.second.unit       = u2u_pkg::LO_SURR | {6'd0, cp[9:0]};
                o_push.second.run_last   = 1'b1;
                o_push.second.string_end = r_fin;
                o_push.count             = u2u_pkg::PUSH_TWO;
            end
        end else if (r_fin) begin
            o_push.first.run_last   = 1'b1;
            o_push.first.string_end = 1'b1;
            o_push.first.truncated  = 1'b1;
            o_push.count            = u2u_pkg::PUSH_ONE;
        end
        if (!advance) begin
            o_push.count = u2u_pkg::PUSH_NONE;
        end
    end

endmodule

// ===== src/u2u_outq.sv =====
// Small result queue: takes up to two units per cycle, hands out one per cycle while ready.
// Depends on u2u_pkg and u2u_out_if.
module u2u_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u2u_pkg::t_push  i_push,
    output logic            o_room,
    u2u_out_if.source       o_out
);

    u2u_pkg::t_result                r_mem [u2u_pkg::QDEPTH];
    logic [u2u_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [u2u_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [u2u_pkg::QCNT_W-1:0]      r_count;
    logic [u2u_pkg::QCNT_W-1:0]      n_count;
    logic                            pop;
    u2u_pkg::t_result                head;

    // room for a surrogate pair
    assign o_room = r_count <= u2u_pkg::QCNT_W'(u2u_pkg::QDEPTH - 2);

    assign head             = r_mem[r_rd_ptr];
    assign o_out.valid      = r_count != '0;
    assign o_out.unit       = head.unit;
    assign o_out.run_last   = head.run_last;
    assign o_out.string_end = head.string_end;
    assign o_out.truncated  = head.truncated;
    assign pop              = o_out.valid && o_out.ready;

    always_comb begin
        n_count = r_count + {{(u2u_pkg::QCNT_W-2){1'b0}}, i_push.count};
        if (pop) begin
            n_count = n_count - u2u_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.count[u2u_pkg::QPTR_W-1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + u2u_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != u2u_pkg::PUSH_NONE) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == u2u_pkg::PUSH_TWO) begin
            r_mem[r_wr_ptr + u2u_pkg::QPTR_W'(1)] <= i_push.second;
        end
    end

endmodule

// ===== src/u2u_checker.sv =====
// Port-level checks for utf8_to_utf16_stream, bound to the top level.
// Depends only on the top level's port signals.
module u2u_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_unit,
    input logic        i_run_last,
    input logic        i_string_end,
    input logic        i_truncated
);

    a_trunc_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_truncated |-> i_unit == 16'd0 && i_run_last && i_string_end)
        else $error("truncation item malformed");

    // out-of-range code points push the high unit up to 0xDFBF, so check the top five bits
    a_mid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_run_last |-> !i_string_end && !i_truncated
            && i_unit[15:11] == 5'b11011)
        else $error("first unit of a byte is not a high surrogate");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("valid dropped while stalled");

    a_hold_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_unit))
        else $error("unit changed while stalled");

endmodule

bind utf8_to_utf16_stream u2u_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_unit       (o_out.unit),
    .i_run_last   (o_out.run_last),
    .i_string_end (o_out.string_end),
    .i_truncated  (o_out.truncated)
);

// ===== bench/utf8_to_utf16_stream_tb.sv =====
// Self-checking bench for utf8_to_utf16_stream: drives UTF-8 bytes, predicts UTF-16 units.
// Depends on u2u_pkg, the u2u_in_if / u2u_out_if interfaces and the transcoder top level.
module utf8_to_utf16_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [u2u_pkg::BYTE_W-1:0] b;
        logic                       fin;
    } t_byte_item;

    logic clk;
    logic rst_n;
    int   cycle_cnt;
    int   errors;
    logic byte_taken;
    wire  calm = (cycle_cnt >= 400) && (cycle_cnt < 900);

    t_byte_item       byte_q[$];
    u2u_pkg::t_result unit_q[$];

    // Decoder state mirrored by the predictor
    logic [1:0]               seq_left;
    logic [u2u_pkg::CP_W-1:0] cp_acc;

    u2u_in_if  in_ch ();
    u2u_out_if out_ch ();

    utf8_to_utf16_stream i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic push_unit(input logic [u2u_pkg::UNIT_W-1:0] u, input logic last,
                             input logic send, input logic trunc);
        u2u_pkg::t_result r;
        r.unit       = u;
        r.run_last   = last;
        r.string_end = send;
        r.truncated  = trunc;
        unit_q.insert(unit_q.size(), r);
    endtask

    task automatic decode_byte(input logic [u2u_pkg::BYTE_W-1:0] b, input logic fin);
        logic                     done;
        logic [u2u_pkg::CP_W-1:0] off;
        done = 1'b0;
        if (seq_left == u2u_pkg::PEND_NONE) begin
            if (b[7] == 1'b0) begin
                cp_acc = u2u_pkg::CP_W'(b);
                done   = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                cp_acc   = u2u_pkg::CP_W'(b[4:0]);
                seq_left = u2u_pkg::PEND_ONE;
            end else if (b[7:4] == 4'b1110) begin
                cp_acc   = u2u_pkg::CP_W'(b[3:0]);
                seq_left = u2u_pkg::PEND_TWO;
            end else begin
                // stray continuations and 0xF8..0xFF land here too
                cp_acc   = u2u_pkg::CP_W'(b[2:0]);
                seq_left = u2u_pkg::PEND_3;
            end
        end else begin
            cp_acc   = {cp_acc[u2u_pkg::CP_W-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            done     = (seq_left == u2u_pkg::PEND_NONE);
        end

        if (done) begin
            if (cp_acc < u2u_pkg::CP_PLANE1) begin
                push_unit(cp_acc[u2u_pkg::UNIT_W-1:0], 1'b1, fin, 1'b0);
            end else begin
                off = cp_acc - u2u_pkg::CP_PLANE1;
                push_unit(u2u_pkg::HI_SURR + u2u_pkg::UNIT_W'(off[u2u_pkg::CP_W-1:10]),
                          1'b0, 1'b0, 1'b0);
                push_unit(u2u_pkg::LO_SURR + u2u_pkg::UNIT_W'(cp_acc[9:0]), 1'b1, fin, 1'b0);
            end
            cp_acc = '0;
        end else if (fin) begin
            // string ended inside a sequence: drop the partial code point
            push_unit('0, 1'b1, 1'b1, 1'b1);
        end

        if (fin) begin
            seq_left = u2u_pkg::PEND_NONE;
            cp_acc   = '0;
        end
    endtask

    task automatic flag(input string field, input int unsigned want, input int unsigned got);
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        errors++;
    endtask

    task automatic add_byte(input logic [u2u_pkg::BYTE_W-1:0] b, input logic fin);
        t_byte_item it;
        it.b   = b;
        it.fin = fin;
        byte_q.insert(byte_q.size(), it);
    endtask

    // Driver: present the next pending byte at the falling edge
    always @(negedge clk) begin : drive
        t_byte_item it;
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 11);
            if (!in_ch.valid || byte_taken) begin
                if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
                    it = byte_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.byte_in    <= it.b;
                    in_ch.final_byte <= it.fin;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check units and predict from accepted bytes at the rising edge
    always @(posedge clk) begin : watch
        u2u_pkg::t_result want;
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                if (unit_q.size() == 0) begin
                    $display("%0t: unexpected unit: expected none, got %h", $time,
                             out_ch.unit);
                    errors++;
                end else begin
                    want = unit_q.pop_front();
                    if (out_ch.unit !== want.unit)
                        flag("unit", want.unit, out_ch.unit);
                    if (out_ch.run_last !== want.run_last)
                        flag("run_last", want.run_last, out_ch.run_last);
                    if (out_ch.string_end !== want.string_end)
                        flag("string_end", want.string_end, out_ch.string_end);
                    if (out_ch.truncated !== want.truncated)
                        flag("truncated", want.truncated, out_ch.truncated);
                end
            end
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.byte_in, in_ch.final_byte);
        end
    end

    initial begin
        int          len;
        int          keep;
        logic [7:0]  b;
        logic        fin;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cycle_cnt        = 0;
        errors           = 0;
        seq_left         = u2u_pkg::PEND_NONE;
        cp_acc           = '0;
        in_ch.valid      = 1'b0;
        in_ch.byte_in    = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready     = 1'b0;

        // Directed: ASCII extremes, each sequence length, surrogates, odd leads, cut-offs
        add_byte(8'h00, 1'b1);
        add_byte(8'h7F, 1'b1);
        add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);
        add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b1);
        add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b1);
        add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h80, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h40, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
        add_byte(8'hC0, 1'b1);
        add_byte(8'hF4, 1'b1);

        // Random: mostly well-formed characters, some noise and cut-off strings
        while (byte_q.size() < 1050) begin
            if ($urandom_range(99) < 12) begin
                add_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
            end else begin
                len = $urandom_range(4, 1);
                case (len)
                    1: b = 8'($urandom_range(127));
                    2: b = 8'hC0 | 8'($urandom_range(31));
                    3: b = 8'hE0 | 8'($urandom_range(15));
                    default: b = 8'hF0 | 8'($urandom_range(7));
                endcase
                keep = len;
                if (len > 1 && $urandom_range(99) < 6)
                    keep = $urandom_range(len - 1, 1);
                fin = (keep < len) || ($urandom_range(7) == 0);
                add_byte(b, fin && keep == 1);
                for (int k = 1; k < keep; k++) begin
                    if ($urandom_range(9) == 0)
                        b = 8'($urandom_range(255));
                    else
                        b = 8'h80 | 8'($urandom_range(63));
                    add_byte(b, fin && k == keep - 1);
                end
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: hold until every byte is in and every unit is out
        do @(negedge clk);
        while (byte_q.size() != 0 || in_ch.valid || unit_q.size() != 0);
        repeat (20) @(negedge clk);

        if (unit_q.size() != 0) begin
            $display("%0t: %0d expected units never arrived", $time, unit_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #200000;
        $display("Verification failed");
        $finish;
    end

endmodule
